// File: rtl/hsha_pkg.sv
// Package for the hour-slot histogram averager.
// Holds the sequencer state type, mode and status codes, bin geometry and the
// bin index helper. No dependencies.
package hsha_pkg;

  localparam int unsigned NUM_HOURS      = 24;
  localparam int unsigned SLOTS_PER_HOUR = 6;
  localparam int unsigned SLOT_MINUTES   = 10;
  localparam int unsigned LAST_MINUTE    = 59;
  localparam int unsigned NUM_BINS       = NUM_HOURS * SLOTS_PER_HOUR;
  localparam int unsigned BIN_IDX_W      = $clog2(NUM_BINS);
  localparam int unsigned DIVISOR_W      = 16;
  localparam int unsigned OUT_W          = 32;
  localparam int unsigned DAYS_W         = 6;

  localparam logic [1:0] MODE_RECORD = 2'd0;
  localparam logic [1:0] MODE_DIVIDE = 2'd1;
  localparam logic [1:0] MODE_READ   = 2'd2;
  localparam logic [1:0] MODE_CLEAR  = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_RANGE    = 2'd1;
  localparam logic [1:0] ST_ZERO_DIV = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ACCESS,
    S_DIV_RD,
    S_DIV_LOAD,
    S_DIV_RUN,
    S_EMIT
  } state_t;

  // Command from the sequencer to the bin store.
  typedef struct packed {
    logic                 rd_en;
    logic                 wr_en;
    logic                 clr_all;
    logic [BIN_IDX_W-1:0] addr;
  } bin_cmd_t;

  function automatic logic in_range(input logic [4:0] hour, input logic [5:0] minute);
    in_range = (32'(hour) < NUM_HOURS) && (32'(minute) <= LAST_MINUTE);
  endfunction

  // Bin number hour*6 + minute/10, with the slot taken from a compare ladder.
  function automatic logic [BIN_IDX_W-1:0] bin_of(input logic [4:0] hour,
                                                  input logic [5:0] minute);
    logic [BIN_IDX_W-1:0] slot;
    logic [BIN_IDX_W-1:0] h;
    slot = '0;
    for (int unsigned k = 1; k < SLOTS_PER_HOUR; k++) begin
      if (32'(minute) >= k * SLOT_MINUTES) begin
        slot = BIN_IDX_W'(k);
      end
    end
    h = BIN_IDX_W'(hour);
    bin_of = (h << 2) + (h << 1) + slot;
  endfunction

endpackage

// File: rtl/hsha_div.sv
// Shared restoring divider: one quotient bit per cycle.
// Depends on hsha_pkg for the divisor width.
module hsha_div #(
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic [COUNT_WIDTH-1:0]           dividend,
  input  logic [hsha_pkg::DIVISOR_W-1:0]   divisor,
  output logic                             done,
  output logic [COUNT_WIDTH-1:0]           quotient
);

  localparam int unsigned CW = $clog2(COUNT_WIDTH + 1);
  localparam int unsigned DW = hsha_pkg::DIVISOR_W;

  logic [CW-1:0]          cnt_r, cnt_nxt;
  logic                   done_r, done_nxt;
  logic [DW-1:0]          rem_r, rem_nxt;
  logic [COUNT_WIDTH-1:0] quo_r, quo_nxt;
  logic [DW-1:0]          div_r, div_nxt;
  logic [DW:0]            trial;
  logic                   take;

  always_comb begin
    trial    = {rem_r, quo_r[COUNT_WIDTH-1]};
    take     = trial >= {1'b0, div_r};
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    div_nxt  = div_r;
    if (start) begin
      cnt_nxt = CW'(COUNT_WIDTH);
      rem_nxt = '0;
      quo_nxt = dividend;
      div_nxt = divisor;
    end else if (cnt_r != '0) begin
      // The remainder stays below the divisor, so the low bits always fit.
      rem_nxt  = take ? DW'(trial - {1'b0, div_r}) : trial[DW-1:0];
      quo_nxt  = {quo_r[COUNT_WIDTH-2:0], take};
      cnt_nxt  = cnt_r - CW'(1);
      done_nxt = (cnt_r == CW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    div_r <= div_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// File: rtl/hsha_bins.sv
// Bin store: 144-entry count memory with a registered read port and one
// valid flag per entry, so that a clear resets every entry at once. Depends on hsha_pkg.
module hsha_bins #(
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  hsha_pkg::bin_cmd_t     cmd,
  input  logic [COUNT_WIDTH-1:0] wdata,
  output logic [COUNT_WIDTH-1:0] rdata
);

  logic [COUNT_WIDTH-1:0]        mem [0:hsha_pkg::NUM_BINS-1];
  logic [hsha_pkg::NUM_BINS-1:0] valid_r;
  logic [COUNT_WIDTH-1:0]        rmem_r;
  logic                          rvalid_r;

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[cmd.addr] <= wdata;
    end
    if (cmd.rd_en) begin
      rmem_r <= mem[cmd.addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rvalid_r <= 1'b0;
    end else begin
      if (cmd.clr_all) begin
        valid_r <= '0;
      end else if (cmd.wr_en) begin
        valid_r[cmd.addr] <= 1'b1;
      end
      if (cmd.rd_en) begin
        rvalid_r <= valid_r[cmd.addr];
      end
    end
  end

  // An entry never written since reset or clear reads as zero.
  assign rdata = rvalid_r ? rmem_r : '0;

endmodule

// File: rtl/hour_slot_histogram_averager_top.sv
// Top level of the hour-slot histogram averager: sequencer, day set, output
// register. Depends on hsha_pkg, hsha_bins and hsha_div.
//
//   channel | direction | ports
//   in      | input     | in_valid, in_stall, in_mode, in_day, in_hour, in_minute, in_divisor
//   out     | output    | out_valid, out_stall, out_count_value, out_peak_count,
//           |           | out_distinct_days, out_status
//
// A record or read issues its memory read on acceptance, updates in S_ACCESS, then passes
// S_EMIT, which loads the output register; a clear or a rejected item goes straight to S_EMIT.
// A divide takes each bin through S_DIV_RD, S_DIV_LOAD and S_DIV_RUN; the shared
// one-bit-per-cycle divider handles every bin in turn. The block takes one item at a
// time and is ready again right after the output register loads.
// Reset clears the bin valid flags and the day set.
// A stalled result holds the sequencer until the output register frees up.
module hour_slot_histogram_averager_top #(
  parameter int unsigned COUNT_WIDTH  = 32,
  parameter int unsigned DAY_SET_SIZE = 32
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [1:0]                           in_mode,
  input  logic [4:0]                           in_day,
  input  logic [4:0]                           in_hour,
  input  logic [5:0]                           in_minute,
  input  logic [hsha_pkg::DIVISOR_W-1:0]       in_divisor,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [hsha_pkg::OUT_W-1:0]           out_count_value,
  output logic [hsha_pkg::OUT_W-1:0]           out_peak_count,
  output logic [hsha_pkg::DAYS_W-1:0]          out_distinct_days,
  output logic [1:0]                           out_status
);

  localparam int unsigned IW = hsha_pkg::BIN_IDX_W;
  localparam int unsigned OW = hsha_pkg::OUT_W;
  localparam int unsigned DW = hsha_pkg::DAYS_W;

  hsha_pkg::state_t        state_r, state_nxt;
  logic                    is_record_r, is_record_nxt;
  logic [DAY_SET_SIZE-1:0] day_bit_r, day_bit_nxt;
  logic [DAY_SET_SIZE-1:0] days_r, days_nxt;
  logic [DW-1:0]           distinct_r, distinct_nxt;
  logic [IW-1:0]           idx_r, idx_nxt;
  logic [hsha_pkg::DIVISOR_W-1:0] divisor_r, divisor_nxt;
  logic [COUNT_WIDTH-1:0]  res_count_r, res_count_nxt;
  logic [COUNT_WIDTH-1:0]  res_max_r, res_max_nxt;
  logic [1:0]              res_status_r, res_status_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [OW-1:0]           out_count_r, out_count_nxt;
  logic [OW-1:0]           out_max_r, out_max_nxt;
  logic [DW-1:0]           out_days_r, out_days_nxt;
  logic [1:0]              out_status_r, out_status_nxt;

  hsha_pkg::bin_cmd_t      cmd;
  logic [COUNT_WIDTH-1:0]  wdata;
  logic [COUNT_WIDTH-1:0]  rdata;
  logic                    div_start;
  logic                    div_done;
  logic [COUNT_WIDTH-1:0]  quotient;
  logic [COUNT_WIDTH-1:0]  inc_val;
  logic                    accept;
  logic                    hm_ok;
  logic [COUNT_WIDTH+OW-1:0] count_ext;
  logic [COUNT_WIDTH+OW-1:0] max_ext;

  hsha_bins #(.COUNT_WIDTH(COUNT_WIDTH)) u_bins (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd),
    .wdata (wdata),
    .rdata (rdata)
  );

  hsha_div #(.COUNT_WIDTH(COUNT_WIDTH)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (rdata),
    .divisor  (divisor_r),
    .done     (div_done),
    .quotient (quotient)
  );

  assign accept    = in_valid && (state_r == hsha_pkg::S_IDLE);
  assign hm_ok     = hsha_pkg::in_range(in_hour, in_minute);
  assign inc_val   = (&rdata) ? rdata : rdata + COUNT_WIDTH'(1);
  assign count_ext = {{OW{1'b0}}, res_count_r};
  assign max_ext   = {{OW{1'b0}}, res_max_r};

  always_comb begin
    state_nxt      = state_r;
    is_record_nxt  = is_record_r;
    day_bit_nxt    = day_bit_r;
    days_nxt       = days_r;
    distinct_nxt   = distinct_r;
    idx_nxt        = idx_r;
    divisor_nxt    = divisor_r;
    res_count_nxt  = res_count_r;
    res_max_nxt    = res_max_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_count_nxt  = out_count_r;
    out_max_nxt    = out_max_r;
    out_days_nxt   = out_days_r;
    out_status_nxt = out_status_r;
    cmd            = '0;
    wdata          = inc_val;
    div_start      = 1'b0;

    case (state_r)
      hsha_pkg::S_IDLE: begin
        if (accept) begin
          is_record_nxt  = (in_mode == hsha_pkg::MODE_RECORD);
          // A day beyond the set shifts out and marks nothing.
          day_bit_nxt    = {{(DAY_SET_SIZE-1){1'b0}}, 1'b1} << in_day;
          divisor_nxt    = in_divisor;
          idx_nxt        = '0;
          res_count_nxt  = '0;
          res_max_nxt    = '0;
          res_status_nxt = hsha_pkg::ST_OK;
          case (in_mode)
            hsha_pkg::MODE_RECORD, hsha_pkg::MODE_READ: begin
              if (hm_ok) begin
                cmd.rd_en = 1'b1;
                cmd.addr  = hsha_pkg::bin_of(in_hour, in_minute);
                idx_nxt   = hsha_pkg::bin_of(in_hour, in_minute);
                state_nxt = hsha_pkg::S_ACCESS;
              end else begin
                res_status_nxt = hsha_pkg::ST_RANGE;
                state_nxt      = hsha_pkg::S_EMIT;
              end
            end
            hsha_pkg::MODE_DIVIDE: begin
              if (in_divisor == '0) begin
                res_status_nxt = hsha_pkg::ST_ZERO_DIV;
                state_nxt      = hsha_pkg::S_EMIT;
              end else begin
                state_nxt = hsha_pkg::S_DIV_RD;
              end
            end
            default: begin
              cmd.clr_all  = 1'b1;
              days_nxt     = '0;
              distinct_nxt = '0;
              state_nxt    = hsha_pkg::S_EMIT;
            end
          endcase
        end
      end

      hsha_pkg::S_ACCESS: begin
        if (is_record_r) begin
          cmd.wr_en     = 1'b1;
          cmd.addr      = idx_r;
          res_count_nxt = inc_val;
          days_nxt      = days_r | day_bit_r;
          if ((day_bit_r & ~days_r) != '0) begin
            distinct_nxt = distinct_r + DW'(1);
          end
        end else begin
          res_count_nxt = rdata;
        end
        state_nxt = hsha_pkg::S_EMIT;
      end

      hsha_pkg::S_DIV_RD: begin
        cmd.rd_en = 1'b1;
        cmd.addr  = idx_r;
        state_nxt = hsha_pkg::S_DIV_LOAD;
      end

      hsha_pkg::S_DIV_LOAD: begin
        div_start = 1'b1;
        state_nxt = hsha_pkg::S_DIV_RUN;
      end

      hsha_pkg::S_DIV_RUN: begin
        if (div_done) begin
          cmd.wr_en = 1'b1;
          cmd.addr  = idx_r;
          wdata     = quotient;
          if (quotient > res_max_r) begin
            res_max_nxt = quotient;
          end
          if (32'(idx_r) == hsha_pkg::NUM_BINS - 1) begin
            state_nxt = hsha_pkg::S_EMIT;
          end else begin
            idx_nxt   = idx_r + IW'(1);
            state_nxt = hsha_pkg::S_DIV_RD;
          end
        end
      end

      hsha_pkg::S_EMIT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_count_nxt  = count_ext[OW-1:0];
          out_max_nxt    = max_ext[OW-1:0];
          out_days_nxt   = distinct_r;
          out_status_nxt = res_status_r;
          state_nxt      = hsha_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = hsha_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= hsha_pkg::S_IDLE;
      days_r      <= '0;
      distinct_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      days_r      <= days_nxt;
      distinct_r  <= distinct_nxt;
      out_valid_r <= out_valid_nxt;
    end
    is_record_r  <= is_record_nxt;
    day_bit_r    <= day_bit_nxt;
    idx_r        <= idx_nxt;
    divisor_r    <= divisor_nxt;
    res_count_r  <= res_count_nxt;
    res_max_r    <= res_max_nxt;
    res_status_r <= res_status_nxt;
    out_count_r  <= out_count_nxt;
    out_max_r    <= out_max_nxt;
    out_days_r   <= out_days_nxt;
    out_status_r <= out_status_nxt;
  end

  assign in_stall          = (state_r != hsha_pkg::S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_count_value   = out_count_r;
  assign out_peak_count    = out_max_r;
  assign out_distinct_days = out_days_r;
  assign out_status        = out_status_r;

endmodule

// File: rtl/hsha_checker.sv
// Port-level checker for the hour-slot histogram averager and its bind.
// Depends on hsha_pkg and hour_slot_histogram_averager_top.
module hsha_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_count_value,
  input logic [31:0] out_peak_count,
  input logic [5:0]  out_distinct_days,
  input logic [1:0]  out_status
);

  // A held transaction keeps its count, peak and status.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_count_value)
      && $stable(out_peak_count) && $stable(out_status))
    else $error("stalled result changed");

  // A rejected hour or minute carries no count and no maximum.
  a_range_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == hsha_pkg::ST_RANGE |-> out_count_value == '0
      && out_peak_count == '0)
    else $error("out-of-range result carries data");

  // A zero divisor reports no maximum and no count.
  a_zdiv_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == hsha_pkg::ST_ZERO_DIV |-> out_peak_count == '0
      && out_count_value == '0)
    else $error("zero-divisor result carries data");

  // Only 32 day numbers exist, and no status beyond the zero-divisor code is produced.
  a_days_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_distinct_days <= 6'd32 && out_status <= hsha_pkg::ST_ZERO_DIV)
    else $error("bad day count or status");

  // Nothing is accepted while the sequencer is busy with an item.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted back to back");

endmodule

bind hour_slot_histogram_averager_top hsha_checker u_hsha_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_count_value   (out_count_value),
  .out_peak_count    (out_peak_count),
  .out_distinct_days (out_distinct_days),
  .out_status        (out_status)
);

// File: tb/hour_slot_histogram_averager_top_tb.sv
// Testbench for hour_slot_histogram_averager_top: directed and random traffic against an
// in-bench model of the hour/slot histogram, with random source gaps and sink stalls.
// Depends on hsha_pkg and the RTL of the block.
module hour_slot_histogram_averager_top_tb;

  localparam int unsigned COUNT_W     = 32;
  localparam int unsigned DAY_SET     = 32;
  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  localparam int unsigned TAIL_CYCLES = 20;
  localparam int unsigned OUT_W       = hsha_pkg::OUT_W;
  localparam int unsigned DAYS_W      = hsha_pkg::DAYS_W;
  localparam int unsigned DIVISOR_W   = hsha_pkg::DIVISOR_W;

  typedef struct packed {
    logic [OUT_W-1:0]  count_value;
    logic [OUT_W-1:0]  peak_count;
    logic [DAYS_W-1:0] distinct_days;
    logic [1:0]        status;
  } hist_result_t;

  logic                 clk;
  logic                 rst_n      = 1'b0;
  logic                 in_valid   = 1'b0;
  logic                 in_stall;
  logic [1:0]           in_mode    = hsha_pkg::MODE_READ;
  logic [4:0]           in_day     = '0;
  logic [4:0]           in_hour    = '0;
  logic [5:0]           in_minute  = '0;
  logic [DIVISOR_W-1:0] in_divisor = '0;
  logic                 out_valid;
  logic                 out_stall  = 1'b0;
  logic [OUT_W-1:0]     out_count_value;
  logic [OUT_W-1:0]     out_peak_count;
  logic [DAYS_W-1:0]    out_distinct_days;
  logic [1:0]           out_status;

  // Shadow copy of the histogram and the day set.
  logic [COUNT_W-1:0] bin_shadow [hsha_pkg::NUM_BINS];
  logic [DAY_SET-1:0] days_shadow;
  hist_result_t       hist_results_due [$];

  int unsigned idle_pct       = 0;
  int unsigned stall_pct      = 0;
  int unsigned cycle_count    = 0;
  int unsigned mismatch_count = 0;
  int unsigned results_seen   = 0;
  int unsigned n_record       = 0;
  int unsigned n_read         = 0;
  int unsigned n_divide       = 0;
  int unsigned n_clear        = 0;
  int unsigned n_flagged      = 0;

  hour_slot_histogram_averager_top #(
    .COUNT_WIDTH (COUNT_W),
    .DAY_SET_SIZE(DAY_SET)
  ) u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_mode          (in_mode),
    .in_day           (in_day),
    .in_hour          (in_hour),
    .in_minute        (in_minute),
    .in_divisor       (in_divisor),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_count_value  (out_count_value),
    .out_peak_count   (out_peak_count),
    .out_distinct_days(out_distinct_days),
    .out_status       (out_status)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Timeout after %0d cycles with %0d results outstanding", cycle_count,
             hist_results_due.size());
    $display("Simulation FAILED");
    $finish;
  end

  // Applies one transaction to the shadow histogram and returns the result it should produce.
  function automatic hist_result_t apply_to_histogram(input logic [1:0] mode,
                                                      input logic [4:0] day,
                                                      input logic [4:0] hour,
                                                      input logic [5:0] minute,
                                                      input logic [DIVISOR_W-1:0] divisor);
    hist_result_t res;
    int unsigned  idx;
    logic         hit;
    res = '0;
    res.status = hsha_pkg::ST_OK;
    hit = (hour < hsha_pkg::NUM_HOURS) && (minute <= hsha_pkg::LAST_MINUTE);
    idx = hour * hsha_pkg::SLOTS_PER_HOUR + minute / hsha_pkg::SLOT_MINUTES;
    case (mode)
      hsha_pkg::MODE_RECORD: begin
        n_record++;
        if (hit) begin
          if (bin_shadow[idx] != {COUNT_W{1'b1}}) begin
            bin_shadow[idx] = bin_shadow[idx] + 1'b1;
          end
          res.count_value = OUT_W'(bin_shadow[idx]);
          if (day < DAY_SET) begin
            days_shadow[day] = 1'b1;
          end
        end else begin
          res.status = hsha_pkg::ST_RANGE;
        end
      end
      hsha_pkg::MODE_DIVIDE: begin
        n_divide++;
        if (divisor == '0) begin
          res.status = hsha_pkg::ST_ZERO_DIV;
        end else begin
          for (int b = 0; b < hsha_pkg::NUM_BINS; b++) begin
            bin_shadow[b] = bin_shadow[b] / divisor;
            if (OUT_W'(bin_shadow[b]) > res.peak_count) begin
              res.peak_count = OUT_W'(bin_shadow[b]);
            end
          end
        end
      end
      hsha_pkg::MODE_READ: begin
        n_read++;
        if (hit) begin
          res.count_value = OUT_W'(bin_shadow[idx]);
        end else begin
          res.status = hsha_pkg::ST_RANGE;
        end
      end
      default: begin
        n_clear++;
        foreach (bin_shadow[b]) bin_shadow[b] = '0;
        days_shadow = '0;
      end
    endcase
    res.distinct_days = DAYS_W'($countones(days_shadow));
    if (res.status != hsha_pkg::ST_OK) n_flagged++;
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [OUT_W-1:0] want_v,
                                 input logic [OUT_W-1:0] got_v);
    $display("MISMATCH at result %0d, cycle %0d: %s expected 0x%0h got 0x%0h",
             results_seen, cycle_count, what, want_v, got_v);
    mismatch_count++;
  endtask

  // Presents one transaction, waits for it to be taken, then maybe leaves a gap.
  task automatic send_item(input logic [1:0] mode, input logic [4:0] day,
                           input logic [4:0] hour, input logic [5:0] minute,
                           input logic [DIVISOR_W-1:0] divisor);
    in_valid   <= 1'b1;
    in_mode    <= mode;
    in_day     <= day;
    in_hour    <= hour;
    in_minute  <= minute;
    in_divisor <= divisor;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    hist_results_due.push_back(apply_to_histogram(mode, day, hour, minute, divisor));
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  always @(posedge clk) begin
    out_stall <= (stall_pct != 0) && ($urandom_range(0, 99) < stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (hist_results_due.size() == 0) begin
        report_mismatch("unexpected result, count_value", '0, out_count_value);
      end else begin
        hist_result_t want;
        want = hist_results_due.pop_front();
        if (out_count_value !== want.count_value)
          report_mismatch("count_value", want.count_value, out_count_value);
        if (out_peak_count !== want.peak_count)
          report_mismatch("peak_count", want.peak_count, out_peak_count);
        if (out_distinct_days !== want.distinct_days)
          report_mismatch("distinct_days", OUT_W'(want.distinct_days),
                          OUT_W'(out_distinct_days));
        if (out_status !== want.status)
          report_mismatch("status", OUT_W'(want.status), OUT_W'(out_status));
      end
      results_seen++;
    end
  end

  task automatic test_reset_contents();
    send_item(hsha_pkg::MODE_READ, 5'd0, 5'd0, 6'd0, 16'hffff);
    send_item(hsha_pkg::MODE_READ, 5'd31, 5'd23, 6'd59, 16'h0000);
  endtask

  task automatic test_record_and_read();
    send_item(hsha_pkg::MODE_RECORD, 5'd0, 5'd0, 6'd0, 16'h0000);
    send_item(hsha_pkg::MODE_RECORD, 5'd31, 5'd23, 6'd59, 16'hffff);
    // Same day again: the distinct-day count must not move.
    send_item(hsha_pkg::MODE_RECORD, 5'd31, 5'd23, 6'd50, 16'h5a5a);
    // Slot boundary: minute 9 and minute 10 land in neighboring bins.
    send_item(hsha_pkg::MODE_RECORD, 5'd17, 5'd12, 6'd9, 16'ha5a5);
    send_item(hsha_pkg::MODE_RECORD, 5'd17, 5'd12, 6'd10, 16'h0001);
    send_item(hsha_pkg::MODE_READ, 5'd3, 5'd23, 6'd55, 16'h0000);
    send_item(hsha_pkg::MODE_READ, 5'd3, 5'd12, 6'd9, 16'hffff);
  endtask

  task automatic test_range_errors();
    // A rejected record must not mark its day either.
    send_item(hsha_pkg::MODE_RECORD, 5'd5, 5'd24, 6'd0, 16'h0000);
    send_item(hsha_pkg::MODE_RECORD, 5'd6, 5'd31, 6'd63, 16'hffff);
    send_item(hsha_pkg::MODE_READ, 5'd0, 5'd0, 6'd60, 16'h0000);
    send_item(hsha_pkg::MODE_READ, 5'd0, 5'd24, 6'd0, 16'h0000);
  endtask

  task automatic test_divide();
    send_item(hsha_pkg::MODE_RECORD, 5'd2, 5'd23, 6'd59, 16'h0000);
    send_item(hsha_pkg::MODE_DIVIDE, 5'd31, 5'd31, 6'd63, 16'h0000);
    send_item(hsha_pkg::MODE_DIVIDE, 5'd0, 5'd0, 6'd0, 16'd1);
    send_item(hsha_pkg::MODE_DIVIDE, 5'd0, 5'd0, 6'd0, 16'd2);
    send_item(hsha_pkg::MODE_READ, 5'd0, 5'd23, 6'd50, 16'h0000);
    send_item(hsha_pkg::MODE_DIVIDE, 5'd31, 5'd31, 6'd63, 16'hffff);
  endtask

  task automatic test_clear();
    send_item(hsha_pkg::MODE_RECORD, 5'd9, 5'd1, 6'd30, 16'h0000);
    send_item(hsha_pkg::MODE_CLEAR, 5'd31, 5'd31, 6'd63, 16'hffff);
    send_item(hsha_pkg::MODE_READ, 5'd9, 5'd1, 6'd30, 16'h0000);
  endtask

  // Mostly well-formed traffic aimed at a few hot bins so that divides see real counts,
  // with occasional out-of-range positions, zero divisors and clears.
  task automatic test_random_traffic(input int unsigned n_items, input int unsigned send_idle,
                                     input int unsigned recv_stall);
    logic [1:0]           mode;
    logic [4:0]           day;
    logic [4:0]           hour;
    logic [5:0]           minute;
    logic [DIVISOR_W-1:0] divisor;
    int unsigned          pick;
    idle_pct  = send_idle;
    stall_pct = recv_stall;
    repeat (n_items) begin
      pick    = $urandom_range(0, 99);
      day     = 5'($urandom_range(0, 31));
      divisor = DIVISOR_W'($urandom);
      if ($urandom_range(0, 1) == 0) begin
        hour   = 5'($urandom_range(0, 2) * 11 + 1);
        minute = 6'($urandom_range(0, 19));
      end else begin
        hour   = 5'($urandom_range(0, hsha_pkg::NUM_HOURS - 1));
        minute = 6'($urandom_range(0, hsha_pkg::LAST_MINUTE));
      end
      if (pick < 55) begin
        mode = hsha_pkg::MODE_RECORD;
      end else if (pick < 78) begin
        mode = hsha_pkg::MODE_READ;
      end else if (pick < 83) begin
        mode = hsha_pkg::MODE_DIVIDE;
        hour   = 5'($urandom);
        minute = 6'($urandom);
        case ($urandom_range(0, 9))
          0:       divisor = '0;
          1, 2:    divisor = DIVISOR_W'($urandom);
          3, 4:    divisor = DIVISOR_W'($urandom_range(4, 20));
          default: divisor = DIVISOR_W'($urandom_range(1, 3));
        endcase
      end else if (pick < 86) begin
        mode   = hsha_pkg::MODE_CLEAR;
        hour   = 5'($urandom);
        minute = 6'($urandom);
      end else begin
        mode = ($urandom_range(0, 1) == 0) ? hsha_pkg::MODE_RECORD : hsha_pkg::MODE_READ;
        if ($urandom_range(0, 1) == 0) hour = 5'($urandom_range(hsha_pkg::NUM_HOURS, 31));
        else minute = 6'($urandom_range(hsha_pkg::LAST_MINUTE + 1, 63));
      end
      send_item(mode, day, hour, minute, divisor);
    end
  endtask

  initial begin
    foreach (bin_shadow[b]) bin_shadow[b] = '0;
    days_shadow = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_contents();
    test_record_and_read();
    test_range_errors();
    test_divide();
    test_clear();
    test_random_traffic(110, 0, 0);
    test_random_traffic(105, 65, 0);
    test_random_traffic(105, 0, 65);
    test_random_traffic(110, 21, 21);

    in_valid  <= 1'b0;
    idle_pct  = 0;
    stall_pct = 0;
    while (hist_results_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (hist_results_due.size() != 0)
      report_mismatch("results still outstanding", hist_results_due.size(), '0);
    $display("Checked %0d results: %0d records, %0d reads, %0d divides, %0d clears, %0d flagged.",
             results_seen, n_record, n_read, n_divide, n_clear, n_flagged);
    $display("Ran %0d cycles across four idle/stall mixes with %0d mismatches.",
             cycle_count, mismatch_count);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/hsha_pkg.sv
rtl/hsha_div.sv
rtl/hsha_bins.sv
rtl/hour_slot_histogram_averager_top.sv
rtl/hsha_checker.sv
tb/hour_slot_histogram_averager_top_tb.sv
